// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro expects aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent.
`define CSEL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define CSEL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CSEL_ASSERT_SAME(lbl, ante, cons, msg)
`define CSEL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- sv/csel_pkg.sv -----
package csel_pkg;

    // Serial divider geometry: (side << 16) / frame size.
    localparam int DIV_NW = 34;
    localparam int DIV_DW = 14;
    localparam int DIV_CW = 6;

    // Configuration register indexes.
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_EXPANSION    = 3'd2;
    localparam logic [2:0] REG_MIN_CROP     = 3'd3;
    localparam logic [2:0] REG_MIN_EXTENT   = 3'd4;
    localparam logic [2:0] REG_MAX_CROPS    = 3'd5;

    // One held person entry.
    typedef struct packed {
        logic [33:0] area;
        logic [16:0] xmin;
        logic [16:0] ymin;
        logic [16:0] width;
        logic [16:0] height;
        logic [15:0] score;
    } person_t;

    // One crop word, last field in the lowest bits.
    typedef struct packed {
        logic [15:0] confidence;
        logic [16:0] height;
        logic [16:0] width;
        logic [16:0] ymin;
        logic [16:0] xmin;
    } crop_t;

endpackage

// ----- sv/csel_div.sv -----
module csel_div
    import csel_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIV_NW-1:0] quotient
);

    // Restoring division, one quotient bit per cycle.
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_NW-1:0] num_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {rem_reg, num_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= dividend;
                rem_reg  <= '0;
                den_reg  <= divisor;
            end else if (busy_reg) begin
                num_reg <= {num_reg[DIV_NW-2:0], fits};
                rem_reg <= fits ? DIV_DW'(trial - {1'b0, den_reg}) : trial[DIV_DW-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_NW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ----- sv/largest_box_square_crop_select_unit.sv -----
// Person crop selector.
// Input words arrive on the s_ channel, one detection box per word. Words flagged as
// persons in s_tuser are kept in an on-chip table ordered by box area, largest first,
// equal areas in arrival order. A word with s_tlast high closes the frame: the block
// then walks the table and sends up to the configured crop limit of square crops on
// the m_ channel, the final one with m_tlast high. A frame without any crop yields one
// word with m_tuser low and m_tlast high.
// A person word keeps s_tready low while its area is formed and it moves past each
// smaller entry of the table in a read and a compare step, after a check of the last
// entry when the table is full; other words leave s_tready high unless they close the
// frame. The table is one memory with a registered read port. Closing a frame is
// dominated per entry visited by two serial divider passes, plus three multiplies.
// s_tready is high only while the block is idle. A finished crop waits in the output
// register while the block keeps working; when the receiver stalls with one crop
// still pending, the block waits until the output register frees.
// Reset empties the table at once (the entries themselves need no clearing) and
// restores the configuration registers to their defaults.
module largest_box_square_crop_select_unit
    import csel_pkg::*;
#(
    parameter int MAX_PERSONS      = 64,
    parameter int MAX_OUTPUT_CROPS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_wdata,
    // Detection input.
    input  logic        s_tvalid,
    output logic        s_tready,
    // box_xmin[16:0], box_ymin[33:17], box_width[50:34], box_height[67:51],
    // confidence[83:68], zero fill above.
    input  logic [87:0] s_tdata,
    // is_person[0]
    input  logic        s_tuser,
    input  logic        s_tlast,
    // Crop output.
    output logic        m_tvalid,
    input  logic        m_tready,
    // crop_left[16:0], crop_top[33:17], crop_width[50:34], crop_height[67:51],
    // crop_confidence[83:68], zero fill above.
    output logic [87:0] m_tdata,
    // crop_valid[0]
    output logic        m_tuser,
    output logic        m_tlast
);

    localparam int AW = $clog2(MAX_PERSONS);
    localparam int CW = $clog2(MAX_PERSONS + 1);
    localparam int NW = $clog2(MAX_OUTPUT_CROPS + 1);

    localparam logic [4:0] S_IDLE      = 5'd0;
    localparam logic [4:0] S_AREA      = 5'd1;
    localparam logic [4:0] S_PLACE     = 5'd2;
    localparam logic [4:0] S_FULL_CHK  = 5'd3;
    localparam logic [4:0] S_SHIFT_RD  = 5'd4;
    localparam logic [4:0] S_SHIFT_CMP = 5'd5;
    localparam logic [4:0] E_START     = 5'd6;
    localparam logic [4:0] E_NEXT      = 5'd7;
    localparam logic [4:0] E_RD        = 5'd8;
    localparam logic [4:0] E_WPX       = 5'd9;
    localparam logic [4:0] E_HPX       = 5'd10;
    localparam logic [4:0] E_SIDE      = 5'd11;
    localparam logic [4:0] E_DIVX_GO   = 5'd12;
    localparam logic [4:0] E_DIVX_WAIT = 5'd13;
    localparam logic [4:0] E_DIVY_GO   = 5'd14;
    localparam logic [4:0] E_DIVY_WAIT = 5'd15;
    localparam logic [4:0] E_EDGEX     = 5'd16;
    localparam logic [4:0] E_EDGEY     = 5'd17;
    localparam logic [4:0] E_PUSH      = 5'd18;
    localparam logic [4:0] E_FINAL     = 5'd19;

    // Clamps a Q0.17 edge to the frame and truncates it to Q0.16.
    function automatic logic [16:0] q17_edge(input logic signed [35:0] v);
        if (v < 36'sd0) begin
            return 17'd0;
        end else if (v > 36'sd131072) begin
            return 17'd65536;
        end
        return v[17:1];
    endfunction

    // Configuration registers.
    logic [13:0] frame_width_reg, frame_height_reg, min_crop_reg;
    logic [14:0] expansion_reg;
    logic [16:0] min_extent_reg;
    logic [2:0]  crop_cap_reg;

    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, pos_reg, idx_reg;
    logic [NW-1:0] n_reg, limit;

    // Captured input word.
    logic [16:0] in_x_reg, in_y_reg, in_w_reg, in_h_reg;
    logic [15:0] in_conf_reg;
    logic        in_person_reg, in_last_reg;
    logic [33:0] area_reg;

    // Person table.
    person_t       mem [MAX_PERSONS];
    person_t       rd_reg, wr_data;
    logic          wr_en;
    logic [AW-1:0] rd_addr, wr_addr;

    // Crop datapath.
    logic [16:0] mul_a, mul_b;
    logic [33:0] mul_p;
    logic [14:0] wpx_reg, hpx_reg, big_px;
    logic [17:0] side_reg, side_raw;
    logic [DIV_NW-1:0] hx_reg, hy_reg, div_q;
    logic [13:0] fw_eff, fh_eff;
    logic        div_start, div_busy, div_done;
    logic [18:0] cx, cy;
    logic [16:0] x0, x1, y0, y1;
    logic [16:0] x0_reg, wd_reg, y0_reg, ht_reg;
    logic        ok_reg;

    crop_t pend_reg, out_reg;
    logic  pend_valid_reg, m_valid_reg, m_user_reg, m_last_reg;
    logic  s_accept, out_free, full, out_load;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign full     = (count_reg == CW'(MAX_PERSONS));
    assign fw_eff   = (frame_width_reg == '0) ? 14'd1 : frame_width_reg;
    assign fh_eff   = (frame_height_reg == '0) ? 14'd1 : frame_height_reg;
    assign limit    = (crop_cap_reg > MAX_OUTPUT_CROPS) ? NW'(MAX_OUTPUT_CROPS)
                                                        : NW'(crop_cap_reg);
    // The output register takes a new word when a held crop moves on or the frame ends.
    assign out_load = ((state_reg == E_PUSH) && ok_reg && out_free && pend_valid_reg) ||
                      ((state_reg == E_FINAL) && out_free);

    // Shared multiplier: area, the two pixel extents and the expanded side.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_AREA: begin
                mul_a = in_w_reg;
                mul_b = in_h_reg;
            end
            E_WPX: begin
                mul_a = rd_reg.width;
                mul_b = {3'b0, fw_eff};
            end
            E_HPX: begin
                mul_a = rd_reg.height;
                mul_b = {3'b0, fh_eff};
            end
            E_SIDE: begin
                mul_a = {2'b0, big_px};
                mul_b = {2'b0, expansion_reg};
            end
            default: ;
        endcase
    end
    assign mul_p    = mul_a * mul_b;
    assign big_px   = (wpx_reg > hpx_reg) ? wpx_reg : hpx_reg;
    assign side_raw = mul_p[29:12];

    assign div_start = (state_reg == E_DIVX_GO) || (state_reg == E_DIVY_GO);

    csel_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend ({side_reg, 16'd0}),
        .divisor  ((state_reg == E_DIVX_GO) ? fw_eff : fh_eff),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    // Centers in Q0.17; the half side is subtracted and added, then clamped.
    assign cx = {1'b0, rd_reg.xmin, 1'b0} + 19'(rd_reg.width);
    assign cy = {1'b0, rd_reg.ymin, 1'b0} + 19'(rd_reg.height);
    assign x0 = q17_edge($signed({17'd0, cx}) - $signed({2'd0, hx_reg}));
    assign x1 = q17_edge($signed({17'd0, cx}) + $signed({2'd0, hx_reg}));
    assign y0 = q17_edge($signed({17'd0, cy}) - $signed({2'd0, hy_reg}));
    assign y1 = q17_edge($signed({17'd0, cy}) + $signed({2'd0, hy_reg}));

    // Table ports. The full check reads the last entry, the insertion walk reads the
    // entry just above the hole, and emission reads the entry being cropped.
    always_comb begin
        case (state_reg)
            S_PLACE:    rd_addr = AW'(MAX_PERSONS - 1);
            S_SHIFT_RD: rd_addr = AW'(pos_reg - 1'b1);
            default:    rd_addr = idx_reg[AW-1:0];
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = pos_reg[AW-1:0];
        wr_data = '{area: area_reg, xmin: in_x_reg, ymin: in_y_reg, width: in_w_reg,
                    height: in_h_reg, score: in_conf_reg};
        if (state_reg == S_SHIFT_RD && pos_reg == '0) begin
            wr_en = 1'b1;
        end else if (state_reg == S_SHIFT_CMP) begin
            wr_en = 1'b1;
            if (rd_reg.area < area_reg) begin
                wr_data = rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_tuser) begin
                        state_next = S_AREA;
                    end else if (s_tlast) begin
                        state_next = E_START;
                    end
                end
            end
            S_AREA:  state_next = S_PLACE;
            S_PLACE: state_next = full ? S_FULL_CHK : S_SHIFT_RD;
            S_FULL_CHK: begin
                if (area_reg <= rd_reg.area) begin
                    state_next = in_last_reg ? E_START : S_IDLE;
                end else begin
                    state_next = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (pos_reg == '0) begin
                    state_next = in_last_reg ? E_START : S_IDLE;
                end else begin
                    state_next = S_SHIFT_CMP;
                end
            end
            S_SHIFT_CMP: begin
                if (rd_reg.area < area_reg) begin
                    state_next = S_SHIFT_RD;
                end else begin
                    state_next = in_last_reg ? E_START : S_IDLE;
                end
            end
            E_START: state_next = E_NEXT;
            E_NEXT: begin
                state_next = (idx_reg < count_reg && n_reg < limit) ? E_RD : E_FINAL;
            end
            E_RD:        state_next = E_WPX;
            E_WPX:       state_next = E_HPX;
            E_HPX:       state_next = E_SIDE;
            E_SIDE:      state_next = E_DIVX_GO;
            E_DIVX_GO:   state_next = E_DIVX_WAIT;
            E_DIVX_WAIT: state_next = div_done ? E_DIVY_GO : E_DIVX_WAIT;
            E_DIVY_GO:   state_next = E_DIVY_WAIT;
            E_DIVY_WAIT: state_next = div_done ? E_EDGEX : E_DIVY_WAIT;
            E_EDGEX:     state_next = E_EDGEY;
            E_EDGEY:     state_next = E_PUSH;
            E_PUSH:      state_next = (!ok_reg || out_free) ? E_NEXT : E_PUSH;
            E_FINAL:     state_next = out_free ? S_IDLE : E_FINAL;
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
            frame_width_reg  <= 14'd1280;
            frame_height_reg <= 14'd720;
            expansion_reg    <= 15'd4710;
            min_crop_reg     <= 14'd192;
            min_extent_reg   <= 17'd1311;
            crop_cap_reg     <= 3'd4;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[13:0];
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[13:0];
                    REG_EXPANSION:    expansion_reg    <= cfg_wdata[14:0];
                    REG_MIN_CROP:     min_crop_reg     <= cfg_wdata[13:0];
                    REG_MIN_EXTENT:   min_extent_reg   <= cfg_wdata;
                    REG_MAX_CROPS:    crop_cap_reg     <= cfg_wdata[2:0];
                    default: ;
                endcase
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        in_x_reg      <= s_tdata[16:0];
                        in_y_reg      <= s_tdata[33:17];
                        in_w_reg      <= s_tdata[50:34];
                        in_h_reg      <= s_tdata[67:51];
                        in_conf_reg   <= s_tdata[83:68];
                        in_person_reg <= s_tuser;
                        in_last_reg   <= s_tlast;
                    end
                end
                S_AREA:  area_reg <= mul_p;
                S_PLACE: pos_reg  <= count_reg;
                S_FULL_CHK: begin
                    // A full table drops its smallest entry to make room.
                    if (area_reg > rd_reg.area) begin
                        pos_reg   <= CW'(MAX_PERSONS - 1);
                        count_reg <= CW'(MAX_PERSONS - 1);
                    end
                end
                S_SHIFT_RD: begin
                    if (pos_reg == '0) begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                S_SHIFT_CMP: begin
                    if (rd_reg.area < area_reg) begin
                        pos_reg <= pos_reg - 1'b1;
                    end else begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                E_START: begin
                    idx_reg <= '0;
                    n_reg   <= '0;
                end
                E_WPX: wpx_reg <= mul_p[30:16];
                E_HPX: hpx_reg <= mul_p[30:16];
                E_SIDE: begin
                    side_reg <= (side_raw < {4'd0, min_crop_reg}) ? {4'd0, min_crop_reg}
                                                                  : side_raw;
                end
                E_DIVX_WAIT: begin
                    if (div_done) begin
                        hx_reg <= div_q;
                    end
                end
                E_DIVY_WAIT: begin
                    if (div_done) begin
                        hy_reg <= div_q;
                    end
                end
                E_EDGEX: begin
                    x0_reg <= x0;
                    wd_reg <= x1 - x0;
                end
                E_EDGEY: begin
                    y0_reg <= y0;
                    ht_reg <= y1 - y0;
                    ok_reg <= (wd_reg >= min_extent_reg) && ((y1 - y0) >= min_extent_reg);
                end
                E_PUSH: begin
                    // A crop is held back one step so that the final one can carry
                    // the end-of-frame mark.
                    if (!ok_reg) begin
                        idx_reg <= idx_reg + 1'b1;
                    end else if (out_free) begin
                        if (pend_valid_reg) begin
                            out_reg     <= pend_reg;
                            m_user_reg  <= 1'b1;
                            m_last_reg  <= 1'b0;
                        end
                        pend_reg       <= '{confidence: rd_reg.score, height: ht_reg,
                                            width: wd_reg, ymin: y0_reg, xmin: x0_reg};
                        pend_valid_reg <= 1'b1;
                        n_reg          <= n_reg + 1'b1;
                        idx_reg        <= idx_reg + 1'b1;
                    end
                end
                E_FINAL: begin
                    if (out_free) begin
                        out_reg        <= pend_valid_reg ? pend_reg : '0;
                        m_user_reg     <= pend_valid_reg;
                        m_last_reg     <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        count_reg      <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, out_reg};
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    `include "assert_macros.svh"

    `CSEL_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(MAX_PERSONS), "table count overflow")
    `CSEL_ASSERT_SAME(a_marker_last, m_tvalid && !m_tuser, m_tlast, "empty marker without last")
    `CSEL_ASSERT_SAME(a_div_idle, div_start, !div_busy, "divider started while busy")
    `CSEL_ASSERT_NEXT(a_frame_clear, state_reg == E_FINAL && out_free, count_reg == '0 && !pend_valid_reg, "frame end left state behind")
    `CSEL_ASSERT_SAME(a_person_path, state_reg == S_AREA, in_person_reg, "insertion without person")

endmodule

// ----- sim/largest_box_square_crop_select_unit_tb.sv -----
module largest_box_square_crop_select_unit_tb
    import csel_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The block's table depth and crop limit, as instantiated below.
    localparam int TABLE_DEPTH = 64;
    localparam int CROP_CAP    = 4;
    // Cycles without any accepted word before the run is declared hung. A frame
    // close may walk the full table, and the receiver may stall for most of that
    // walk.
    localparam int HANG_LIMIT  = 30000;
    // Cycles to let a person word finish its insertion walk after the last crop.
    localparam int SETTLE      = 300;

    // One detection as offered on the s_ channel.
    typedef struct {
        logic        person;
        logic [16:0] x, y, w, h;
        logic [15:0] conf;
        logic        last;
    } det_t;

    // One crop word as seen on the m_ channel.
    typedef struct {
        logic        valid;
        logic [16:0] x, y, w, h;
        logic [15:0] conf;
        logic        last;
    } crop_rec_t;

    // One entry of the area-ordered person roster.
    typedef struct {
        logic [33:0] area;
        logic [16:0] x, y, w, h;
        logic [15:0] conf;
    } held_t;

    // A directed row: the detection, and a typed-in crop where one is obvious.
    typedef struct {
        det_t      d;
        bit        typed;
        crop_rec_t want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = REG_FRAME_WIDTH;
    logic [16:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // Predictor copy of the configuration registers, at their reset values.
    logic [13:0] frame_w_px    = 14'd1280;
    logic [13:0] frame_h_px    = 14'd720;
    logic [14:0] grow_q12      = 15'd4710;
    logic [13:0] min_side_px   = 14'd192;
    logic [16:0] thin_q16      = 17'd1311;
    logic [2:0]  crops_per_frm = 3'd4;

    held_t     roster[$];
    crop_rec_t pending_crops[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_cycles = 0;
    int        quiet_cycles = 0;
    row_t      dir_tab[14];

    largest_box_square_crop_select_unit #(
        .MAX_PERSONS(TABLE_DEPTH),
        .MAX_OUTPUT_CROPS(CROP_CAP)
    ) uut (.*);

    always #2 aclk = ~aclk;

    // Sorted insert: larger areas first, equal areas keep arrival order. A full
    // roster drops the newcomer unless it beats the smallest held entry.
    function automatic void file_person(det_t d);
        held_t e;
        int pos;
        e.area = 34'(d.w) * 34'(d.h);
        e.x = d.x;
        e.y = d.y;
        e.w = d.w;
        e.h = d.h;
        e.conf = d.conf;
        if (roster.size() >= TABLE_DEPTH) begin
            if (e.area <= roster[TABLE_DEPTH-1].area) return;
            void'(roster.pop_back());
        end
        pos = roster.size();
        while (pos > 0 && roster[pos-1].area < e.area) pos--;
        roster.insert(pos, e);
    endfunction

    function automatic longint clamp_q17(longint v);
        if (v < 0) return 0;
        if (v > 131072) return 131072;
        return v;
    endfunction

    // Square crop around one held person; returns 0 when the crop is too thin.
    function automatic bit shape_crop(held_t e, output crop_rec_t c);
        longint fw, fh, wpx, hpx, side, cx, cy, hx, hy, x0, x1, y0, y1;
        fw = (frame_w_px == 0) ? 1 : frame_w_px;
        fh = (frame_h_px == 0) ? 1 : frame_h_px;
        wpx = (longint'(e.w) * fw) >> 16;
        hpx = (longint'(e.h) * fh) >> 16;
        side = ((wpx > hpx ? wpx : hpx) * longint'(grow_q12)) >> 12;
        if (side < min_side_px) side = min_side_px;
        cx = 2 * longint'(e.x) + e.w;
        cy = 2 * longint'(e.y) + e.h;
        hx = (side << 16) / fw;
        hy = (side << 16) / fh;
        x0 = clamp_q17(cx - hx) >> 1;
        x1 = clamp_q17(cx + hx) >> 1;
        y0 = clamp_q17(cy - hy) >> 1;
        y1 = clamp_q17(cy + hy) >> 1;
        c.valid = 1'b1;
        c.x = 17'(x0);
        c.y = 17'(y0);
        c.w = 17'(x1 - x0);
        c.h = 17'(y1 - y0);
        c.conf = e.conf;
        c.last = 1'b0;
        return !((x1 - x0) < thin_q16 || (y1 - y0) < thin_q16);
    endfunction

    // Applies one accepted detection; on the frame's last one, queues its crops.
    function automatic void take_detection(det_t d);
        crop_rec_t c;
        int limit, n;
        if (d.person) file_person(d);
        if (!d.last) return;
        limit = (crops_per_frm > CROP_CAP) ? CROP_CAP : crops_per_frm;
        n = 0;
        foreach (roster[i]) begin
            if (n >= limit) break;
            if (shape_crop(roster[i], c)) begin
                pending_crops = {pending_crops, c};
                n++;
            end
        end
        roster.delete();
        if (n == 0) begin
            c = '{valid: 1'b0, x: '0, y: '0, w: '0, h: '0, conf: '0, last: 1'b1};
            pending_crops = {pending_crops, c};
        end else begin
            pending_crops[pending_crops.size()-1].last = 1'b1;
        end
    endfunction

    // Offers one word, with random idle cycles ahead of it, and waits for the
    // handshake. Called at a falling edge, returns at the falling edge after the handshake.
    task automatic offer_word(det_t d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = {4'b0, d.conf, d.h, d.w, d.y, d.x};
        s_tuser = d.person;
        s_tlast = d.last;
        do @(posedge aclk); while (!s_tready);
        take_detection(d);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [16:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  frame_w_px    = val[13:0];
            REG_FRAME_HEIGHT: frame_h_px    = val[13:0];
            REG_EXPANSION:    grow_q12      = val[14:0];
            REG_MIN_CROP:     min_side_px   = val[13:0];
            REG_MIN_EXTENT:   thin_q16      = val[16:0];
            REG_MAX_CROPS:    crops_per_frm = val[2:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int fw, int fh, int grow, int mside, int thin, int ncrop);
        write_reg(REG_FRAME_WIDTH, 17'(fw));
        write_reg(REG_FRAME_HEIGHT, 17'(fh));
        write_reg(REG_EXPANSION, 17'(grow));
        write_reg(REG_MIN_CROP, 17'(mside));
        write_reg(REG_MIN_EXTENT, 17'(thin));
        write_reg(REG_MAX_CROPS, 17'(ncrop));
    endtask

    // Random detection: mostly persons with moderate boxes inside the frame,
    // now and then any value the 17-bit fields can hold.
    function automatic det_t random_det(bit last);
        det_t d;
        d.person = ($urandom_range(99) < 80);
        d.last = last;
        d.conf = 16'($urandom_range(65535));
        if ($urandom_range(99) < 10) begin
            d.x = 17'($urandom_range(131071));
            d.y = 17'($urandom_range(131071));
            d.w = 17'($urandom_range(131071));
            d.h = 17'($urandom_range(131071));
        end else begin
            d.x = 17'($urandom_range(65536));
            d.y = 17'($urandom_range(65536));
            d.w = 17'($urandom_range(($urandom_range(3) == 0) ? 65536 : 12000));
            d.h = 17'($urandom_range(($urandom_range(3) == 0) ? 65536 : 12000));
        end
        return d;
    endfunction

    // Waits until every crop has arrived and the block has had time to finish
    // any insertion it may still be doing.
    task automatic drain();
        s_tvalid = 1'b0;
        s_tlast = 1'b0;
        while (pending_crops.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // Receiver: random stalls, and a counted hold-off when one is requested.
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: every accepted crop word against the oldest expectation.
    always @(posedge aclk) begin
        crop_rec_t exp_c;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_crops.size() == 0) begin
                $display("%0t: unexpected crop word, expected none, got tdata=%h tuser=%b tlast=%b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                exp_c = pending_crops.pop_front();
                if (m_tuser !== exp_c.valid || m_tlast !== exp_c.last ||
                    m_tdata !== {4'b0, exp_c.conf, exp_c.h, exp_c.w, exp_c.y, exp_c.x}) begin
                    $display("%0t: crop mismatch, expected valid=%b x=%0d y=%0d w=%0d h=%0d conf=%0d last=%b",
                             $time, exp_c.valid, exp_c.x, exp_c.y, exp_c.w, exp_c.h,
                             exp_c.conf, exp_c.last);
                    $display("%0t:                actual   valid=%b x=%0d y=%0d w=%0d h=%0d conf=%0d last=%b",
                             $time, m_tuser, m_tdata[16:0], m_tdata[33:17], m_tdata[50:34],
                             m_tdata[67:51], m_tdata[83:68], m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        det_t d;
        int nframes, flen;
        // Directed rows. The full-frame box under the reset configuration gives a
        // crop clamped to the whole frame; a frame without persons gives only the
        // empty-frame marker.
        dir_tab[0]  = '{'{1'b0, 17'd100, 17'd100, 17'd5000, 17'd5000, 16'd7, 1'b1}, 1'b1,
                        '{1'b0, 17'd0, 17'd0, 17'd0, 17'd0, 16'd0, 1'b1}};
        dir_tab[1]  = '{'{1'b1, 17'd0, 17'd0, 17'd65536, 17'd65536, 16'hFFFF, 1'b1}, 1'b1,
                        '{1'b1, 17'd0, 17'd0, 17'd65536, 17'd65536, 16'hFFFF, 1'b1}};
        // Ordering, ties in arrival order, and a non-person closing the frame.
        dir_tab[2]  = '{'{1'b1, 17'd1000, 17'd2000, 17'd3000, 17'd4000, 16'd1, 1'b0}, 1'b0, '{default: '0}};
        dir_tab[3]  = '{'{1'b1, 17'd30000, 17'd30000, 17'd20000, 17'd20000, 16'd2, 1'b0}, 1'b0, '{default: '0}};
        dir_tab[4]  = '{'{1'b1, 17'd50000, 17'd10000, 17'd4000, 17'd3000, 16'd3, 1'b0}, 1'b0, '{default: '0}};
        dir_tab[5]  = '{'{1'b1, 17'd20000, 17'd40000, 17'd6000, 17'd2000, 16'd4, 1'b0}, 1'b0, '{default: '0}};
        dir_tab[6]  = '{'{1'b1, 17'd0, 17'd0, 17'd0, 17'd0, 16'd5, 1'b0}, 1'b0, '{default: '0}};
        dir_tab[7]  = '{'{1'b0, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 16'd6, 1'b1}, 1'b0, '{default: '0}};
        // Boxes on the far corner, tiny boxes forced up to the minimum side, and
        // fields above one that the block takes as they are.
        dir_tab[8]  = '{'{1'b1, 17'd65536, 17'd65536, 17'd0, 17'd0, 16'd8, 1'b1}, 1'b0, '{default: '0}};
        dir_tab[9]  = '{'{1'b1, 17'd32768, 17'd32768, 17'd10, 17'd10, 16'd9, 1'b0}, 1'b0, '{default: '0}};
        dir_tab[10] = '{'{1'b1, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 16'hAAAA, 1'b0}, 1'b0, '{default: '0}};
        dir_tab[11] = '{'{1'b1, 17'h15555, 17'h0AAAA, 17'h0AAAA, 17'h15555, 16'h5555, 1'b0}, 1'b0, '{default: '0}};
        dir_tab[12] = '{'{1'b0, 17'h0AAAA, 17'h15555, 17'h15555, 17'h0AAAA, 16'h0, 1'b0}, 1'b0, '{default: '0}};
        dir_tab[13] = '{'{1'b1, 17'd40000, 17'd1, 17'd1, 17'd40000, 16'd12, 1'b1}, 1'b0, '{default: '0}};

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[i]) begin
            offer_word(dir_tab[i].d);
            if (dir_tab[i].typed) begin
                pending_crops[pending_crops.size()-1] = dir_tab[i].want;
            end
        end
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: write_all(1, 1, 4096, 0, 0, 1);
                1: write_all(8192, 8192, 16384, 8192, 65536, 4);
                2: write_all(1920, 1080, 4710, 64, 1311, 3);
                3: write_all(0, 16383, 32767, 16383, 131071, 7);
                4: write_all(640, 480, 5000, 100, 20000, 0);
                5: write_all(16383, 0, 0, 0, 600, 2);
                default: write_all($urandom_range(1, 8192), $urandom_range(1, 8192),
                                   $urandom_range(4096, 16384), $urandom_range(0, 400),
                                   $urandom_range(0, 4000), $urandom_range(1, 4));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // A long receiver hold-off while the sender keeps offering words.
            if (ph == 2) hold_cycles = 400;
            // Two phases also run a frame that overflows the person table.
            if (ph == 6 || ph == 8) begin
                for (int k = 0; k < 70; k++) begin
                    d = random_det(k == 69);
                    d.person = 1'b1;
                    if (k % 9 == 0) d.w = 17'd0;
                    offer_word(d);
                end
            end
            nframes = $urandom_range(3, 5);
            for (int f = 0; f < nframes; f++) begin
                flen = $urandom_range(1, 6);
                for (int k = 0; k < flen; k++) begin
                    d = random_det(k == flen - 1);
                    // Sometimes reuse one fixed size to make equal areas.
                    if (k > 0 && $urandom_range(3) == 0) begin
                        d.w = dir_tab[2].d.w;
                        d.h = dir_tab[2].d.h;
                    end
                    offer_word(d);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
